FILE: rtl/keypad_scan_multitap_entry_macros.svh
// assertion macros for the keypad scanner with multi-tap entry
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef KEYPAD_SCAN_MULTITAP_ENTRY_MACROS_SVH
`define KEYPAD_SCAN_MULTITAP_ENTRY_MACROS_SVH

// plain property, checked out of reset
`define KPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication, checked out of reset
`define KPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kpsme_pkg.sv
// shared constants, types and key tables for the keypad scanner
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package kpsme_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int TIMER_BITS = 16;
  localparam int CfgW       = 16;
  localparam int CmpW       = (TIMER_BITS > CfgW) ? TIMER_BITS : CfgW;
  localparam int FillW      = $clog2(FIFO_DEPTH + 1);
  localparam int PtrW       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  // configuration register indexes
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  // scan phase codes
  localparam logic [1:0] PH_SCAN     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HELD     = 2'd2;

  // ascii codes with a role in the control logic
  localparam logic [6:0] CH_ONE   = 7'h31;
  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_HASH  = 7'h23;
  localparam logic [6:0] CH_SPACE = 7'h20;

  typedef struct packed {
    logic       valid;
    logic [6:0] key;
  } key_evt_t;

  typedef struct packed {
    logic       letter_valid;
    logic [6:0] letter;
    logic       direct_valid;
    logic [6:0] direct;
  } push_t;

  function automatic logic [6:0] key_at(input logic [1:0] col, input logic [1:0] row);
    logic [6:0] k;
    k = 7'h00;
    case ({col, row})
      4'b00_00: k = 7'h31;
      4'b00_01: k = 7'h34;
      4'b00_10: k = 7'h37;
      4'b00_11: k = CH_STAR;
      4'b01_00: k = 7'h32;
      4'b01_01: k = 7'h35;
      4'b01_10: k = 7'h38;
      4'b01_11: k = 7'h30;
      4'b10_00: k = 7'h33;
      4'b10_01: k = 7'h36;
      4'b10_10: k = 7'h39;
      4'b10_11: k = CH_HASH;
      default:  k = 7'h00;
    endcase
    return k;
  endfunction

  function automatic logic is_direct(input logic [6:0] key);
    return (key == CH_ONE) || (key == CH_STAR) || (key == CH_HASH);
  endfunction

  function automatic logic [2:0] group_len(input logic [6:0] key);
    logic [2:0] n;
    case (key)
      7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h38: n = 3'd4;
      7'h37, 7'h39:                             n = 3'd5;
      7'h30:                                    n = 3'd2;
      default:                                  n = 3'd0;
    endcase
    return n;
  endfunction

  // first character of the letter group
  function automatic logic [6:0] group_base(input logic [6:0] key);
    logic [6:0] b;
    case (key)
      7'h32:   b = 7'h41;
      7'h33:   b = 7'h44;
      7'h34:   b = 7'h47;
      7'h35:   b = 7'h4A;
      7'h36:   b = 7'h4D;
      7'h37:   b = 7'h50;
      7'h38:   b = 7'h54;
      7'h39:   b = 7'h57;
      7'h30:   b = CH_SPACE;
      default: b = key;
    endcase
    return b;
  endfunction

  // letter at a position; the digit closes every group
  function automatic logic [6:0] group_char(input logic [6:0] key, input logic [2:0] pos);
    logic [2:0] len;
    logic [2:0] sel;
    logic [6:0] c;
    len = group_len(key);
    sel = (pos < len) ? pos : 3'd0;
    if (len == 3'd0) begin
      c = key;
    end else if (sel == len - 3'd1) begin
      c = key;
    end else begin
      c = group_base(key) + {4'd0, sel};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kpsme_scan.sv
// row scan, debounce and key latch; emits a key request on release
// depends on kpsme_pkg
`timescale 1ns / 1ps
`default_nettype none

module kpsme_scan
  import kpsme_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  tick_i,
  input  logic [2:0]            column_sense_i,
  input  logic [CfgW-1:0]       debounce_ticks_i,
  output key_evt_t              evt_o,
  output logic [3:0]            row_drive_o
);

  logic [1:0]            phase_q, phase_d;
  logic [1:0]            row_q, row_d;
  logic [6:0]            held_q, held_d;
  logic [TIMER_BITS-1:0] dcnt_q, dcnt_d, dcnt_inc;
  logic                  contact;
  logic [1:0]            col;

  assign contact = (column_sense_i != 3'b111);
  assign col     = !column_sense_i[0] ? 2'd0 : (!column_sense_i[1] ? 2'd1 : 2'd2);
  assign dcnt_inc = (tick_i && (dcnt_q != '1)) ? dcnt_q + TIMER_BITS'(1) : dcnt_q;

  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    held_d  = held_q;
    dcnt_d  = dcnt_inc;
    evt_o   = '0;
    unique case (phase_q)
      PH_DEBOUNCE: begin
        if (CmpW'(dcnt_inc) >= CmpW'(debounce_ticks_i)) begin
          if (contact) begin
            held_d  = key_at(col, row_q);
            phase_d = PH_HELD;
          end else begin
            phase_d = PH_SCAN;
          end
        end
      end
      PH_HELD: begin
        if (!contact) begin
          evt_o.valid = (held_q != 7'd0);
          evt_o.key   = held_q;
          phase_d     = PH_SCAN;
        end
      end
      default: begin
        row_d   = row_q + 2'd1;
        phase_d = PH_SCAN;
        if (contact) begin
          dcnt_d  = '0;
          phase_d = PH_DEBOUNCE;
        end
      end
    endcase
  end

  assign row_drive_o = ~(4'b0001 << row_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SCAN;
      row_q   <= 2'd0;
      held_q  <= 7'd0;
      dcnt_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      held_q  <= held_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kpsme_multitap.sv
// multi-tap letter entry: timeout, letter cycling and commit requests
// depends on kpsme_pkg
`timescale 1ns / 1ps
`default_nettype none

module kpsme_multitap
  import kpsme_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            tick_i,
  input  key_evt_t        evt_i,
  input  logic [CfgW-1:0] timeout_ticks_i,
  output push_t           push_o
);

  logic                  active_q, active_d;
  logic [6:0]            mkey_q, mkey_d;
  logic [2:0]            pos_q, pos_d, pos_inc;
  logic [TIMER_BITS-1:0] mcnt_q, mcnt_d, mcnt_inc;
  logic                  timeout;
  logic                  still_active;
  logic                  direct;
  logic [2:0]            len;

  assign mcnt_inc     = (tick_i && (mcnt_q != '1)) ? mcnt_q + TIMER_BITS'(1) : mcnt_q;
  assign timeout      = active_q && (CmpW'(mcnt_inc) >= CmpW'(timeout_ticks_i));
  assign still_active = active_q && !timeout;
  assign direct       = is_direct(evt_i.key);
  assign len          = group_len(evt_i.key);
  assign pos_inc      = pos_q + 3'd1;

  always_comb begin
    active_d = still_active;
    mkey_d   = mkey_q;
    pos_d    = pos_q;
    mcnt_d   = mcnt_inc;
    push_o   = '0;
    push_o.letter = group_char(mkey_q, pos_q);
    push_o.direct = evt_i.key;
    if (timeout) begin
      push_o.letter_valid = 1'b1;
    end
    if (evt_i.valid) begin
      if (direct) begin
        push_o.letter_valid = active_q;
        push_o.direct_valid = 1'b1;
        active_d            = 1'b0;
      end else if (still_active && (evt_i.key == mkey_q)) begin
        pos_d  = ((len == 3'd0) || (pos_inc >= len)) ? 3'd0 : pos_inc;
        mcnt_d = '0;
      end else begin
        push_o.letter_valid = active_q;
        active_d            = 1'b1;
        mkey_d              = evt_i.key;
        pos_d               = 3'd0;
        mcnt_d              = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      mkey_q   <= 7'd0;
      pos_q    <= 3'd0;
      mcnt_q   <= '0;
    end else if (en_i) begin
      active_q <= active_d;
      mkey_q   <= mkey_d;
      pos_q    <= pos_d;
      mcnt_q   <= mcnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kpsme_fifo.sv
// character fifo: up to two pushes then one pop per step, drops when full
// depends on kpsme_pkg
`timescale 1ns / 1ps
`default_nettype none

module kpsme_fifo
  import kpsme_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  push_t      push_i,
  input  logic       pop_i,
  output logic       pop_valid_o,
  output logic [6:0] pop_char_o,
  output logic       not_empty_o
);

  logic [6:0]       store_q [FIFO_DEPTH];
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_1, tail_d;
  logic [FillW-1:0] fill_q, fill_1, fill_2, fill_d;
  logic             acc0, acc1;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(FIFO_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    acc0   = push_i.letter_valid && (fill_q < FillW'(FIFO_DEPTH));
    fill_1 = acc0 ? fill_q + FillW'(1) : fill_q;
    tail_1 = acc0 ? ptr_next(tail_q) : tail_q;
    acc1   = push_i.direct_valid && (fill_1 < FillW'(FIFO_DEPTH));
    fill_2 = acc1 ? fill_1 + FillW'(1) : fill_1;
    tail_d = acc1 ? ptr_next(tail_1) : tail_1;
    pop_valid_o = pop_i && (fill_2 != '0);
    if (!pop_valid_o) begin
      pop_char_o = 7'd0;
    end else if (fill_q != '0) begin
      pop_char_o = store_q[head_q];
    end else if (acc0) begin
      pop_char_o = push_i.letter;
    end else begin
      pop_char_o = push_i.direct;
    end
    head_d = pop_valid_o ? ptr_next(head_q) : head_q;
    fill_d = pop_valid_o ? fill_2 - FillW'(1) : fill_2;
    not_empty_o = (fill_d != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i && acc0) begin
      store_q[tail_q] <= push_i.letter;
    end
    if (en_i && acc1) begin
      store_q[tail_1] <= push_i.direct;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (en_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/keypad_scan_multitap_entry.sv
// top level of the keypad scanner: request registers, config registers, result register
// depends on kpsme_pkg, kpsme_scan, kpsme_multitap, kpsme_fifo and the macros header
// Keypad scanner with multi-tap entry. Each input request is one scan step for a 4x3
// active-low matrix (tick, column sense of the driven row, pop request); each step gives
// exactly one result (row drive after the step, popped character, fifo non-empty flag).
// A request is taken into an input register, the whole step runs as combinational logic
// against the state registers, and the result lands in an output register. One request is
// taken every cycle while the result side keeps up. Both configuration registers should
// be written only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_scan_multitap_entry_macros.svh"

module keypad_scan_multitap_entry
  import kpsme_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,  // tick, column_sense[2:0], pop_req, zero pad
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,  // row_drive[3:0], char_valid, char_out[6:0],
                                         // chars_waiting, zero pad
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic            in_valid_q;
  logic            tick_q, pop_q;
  logic [2:0]      cols_q;
  logic            out_valid_q;
  logic [15:0]     out_data_q;
  logic            out_free, step_en;
  logic [CfgW-1:0] debounce_q, timeout_q;
  key_evt_t        evt;
  push_t           push;
  logic [3:0]      row_drive;
  logic            pop_valid, not_empty;
  logic [6:0]      pop_char;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_en       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= CfgW'(20);
      timeout_q  <= CfgW'(1000);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
        default:      debounce_q <= debounce_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tick_q <= s_axis_tdata[0];
      cols_q <= s_axis_tdata[3:1];
      pop_q  <= s_axis_tdata[4];
    end
    if (step_en) begin
      out_data_q <= {3'd0, not_empty, pop_char, pop_valid, row_drive};
    end
  end

  kpsme_scan u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (step_en),
    .tick_i           (tick_q),
    .column_sense_i   (cols_q),
    .debounce_ticks_i (debounce_q),
    .evt_o            (evt),
    .row_drive_o      (row_drive)
  );

  kpsme_multitap u_multitap (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (step_en),
    .tick_i          (tick_q),
    .evt_i           (evt),
    .timeout_ticks_i (timeout_q),
    .push_o          (push)
  );

  kpsme_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (step_en),
    .push_i      (push),
    .pop_i       (pop_q),
    .pop_valid_o (pop_valid),
    .pop_char_o  (pop_char),
    .not_empty_o (not_empty)
  );

  `KPS_ASSERT_IMPL(a_row_one_cold, m_axis_tvalid,
                   $countones(m_axis_tdata[3:0]) == 3, "row drive not one-cold")
  `KPS_ASSERT_IMPL(a_no_char_zero, m_axis_tvalid && !m_axis_tdata[4],
                   m_axis_tdata[11:5] == 7'd0, "char out set without char valid")
  `KPS_ASSERT_IMPL(a_char_nonzero, m_axis_tvalid && m_axis_tdata[4],
                   m_axis_tdata[11:5] != 7'd0, "popped character is zero")
  `KPS_ASSERT(a_pad_zero, !m_axis_tvalid || (m_axis_tdata[15:13] == 3'd0),
              "result padding not zero")

endmodule

`default_nettype wire
